// ===== hdl/cumulative_rate_per_100k_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cumulative rate block
// Concurrent checks, clocked on clk and held off during reset. Both forms
// compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CUMULATIVE_RATE_PER_100K_TOP_DEFINES_SVH
`define CUMULATIVE_RATE_PER_100K_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check
`define CRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check
`define CRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CRP_ASSERT_IMP(lbl, ante, cons, msg)
`define CRP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// Shared widths, constants and controller/datapath interface types for the
// cumulative rate per 100000 block.
// ----------------------------------------------------------------------------
package crp_pkg;

	localparam int TOTAL_W     = 32;
	localparam int POP_W       = 34;
	localparam int RATE_W      = 64;
	localparam int PER_W       = 17;
	localparam int NUM_W       = TOTAL_W + PER_W;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [PER_W-1:0]   PER_PEOPLE = 17'd100000;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
	localparam logic [RATE_W-1:0]  RATE_MAX   = '1;
	localparam logic [POP_W-1:0]   POP_RESET  = 34'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;      // capture input item, update running total
		logic start;     // scale total and load divider
		logic step;      // one restoring division step
		logic load_out;  // move result into output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_step; // current division step is the final one
	} sts_t;

endpackage

// ===== hdl/cumulative_rate_per_100k_top.sv =====
// ----------------------------------------------------------------------------
// cumulative_rate_per_100k_top
// Running case total and cumulative rate per 100000 people over a series.
// ----------------------------------------------------------------------------
// Each accepted day adds its case count to a saturating running total and
// returns that total with total * 100000 * 2^FRACTION_BITS / population,
// floored and saturated to 64 bits. An item is captured, scaled, run through
// the restoring divider that produces one quotient bit per cycle, and loaded
// into the output register, a load that waits while an earlier result there
// is not yet transferred; only then is the next day accepted. The next day is
// taken while a result still waits in the output register. A day with tlast
// set ends the series and the total restarts.
module cumulative_rate_per_100k_top #(
	parameter int FRACTION_BITS = crp_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        population_we,
	input  logic [33:0] population_wdata,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] daily_cases
	input  logic        s_axis_tlast,   // last_day
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // [63:0] cases_per_100k, [95:64] running_total
	output logic        m_axis_tuser    // [0] total_saturated
);

	crp_pkg::cmd_t cmd;
	crp_pkg::sts_t sts;

	// Sequencer
	crp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	// Arithmetic
	crp_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cases     (s_axis_tdata),
		.last_day  (s_axis_tlast),
		.pop_we    (population_we),
		.pop_wdata (population_wdata),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

endmodule

// ===== hdl/crp_ctrl.sv =====
// ----------------------------------------------------------------------------
// crp_ctrl
// Sequencer for one item: capture, scale, divide bit by bit, then hand the
// result to the output register. Owns the stream handshakes.
// ----------------------------------------------------------------------------
`include "cumulative_rate_per_100k_top_defines.svh"

module crp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output crp_pkg::cmd_t cmd,
	input  crp_pkg::sts_t sts
);

	crp_pkg::state_t state_q, state_d;
	logic            m_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			crp_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.take = 1'b1;
					state_d  = crp_pkg::ST_MUL;
				end
			end
			crp_pkg::ST_MUL: begin
				cmd.start = 1'b1;
				state_d   = crp_pkg::ST_DIV;
			end
			crp_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					state_d = crp_pkg::ST_DONE;
				end
			end
			crp_pkg::ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					cmd.load_out = 1'b1;
					state_d      = crp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crp_pkg::ST_IDLE;
			end
		endcase
	end

	// Output valid: set on load, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;

	`CRP_ASSERT_IMP(a_load_free, cmd.load_out, !m_valid_q || m_axis_tready, "result overwritten before transfer")
	`CRP_ASSERT_NXT(a_take_mul, s_axis_tvalid && s_axis_tready, state_q == crp_pkg::ST_MUL, "accepted item did not start scaling")
	`CRP_ASSERT_NXT(a_div_end, cmd.step && sts.last_step, state_q == crp_pkg::ST_DONE, "division did not finish after last step")

endmodule

// ===== hdl/crp_dp.sv =====
// ----------------------------------------------------------------------------
// crp_dp
// Datapath: population register, saturating running total, scale by 100000,
// restoring divider one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module crp_dp #(
	parameter int FRACTION_BITS = crp_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crp_pkg::cmd_t               cmd,
	output crp_pkg::sts_t               sts,
	input  logic [crp_pkg::TOTAL_W-1:0] cases,
	input  logic                        last_day,
	input  logic                        pop_we,
	input  logic [crp_pkg::POP_W-1:0]   pop_wdata,
	output logic [95:0]                 out_tdata,
	output logic                        out_tuser
);

	localparam int DIV_W = crp_pkg::NUM_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(DIV_W);

	logic [crp_pkg::POP_W-1:0]   pop_q;
	logic [crp_pkg::TOTAL_W-1:0] case_total_q;
	logic [crp_pkg::TOTAL_W-1:0] total_q;
	logic [crp_pkg::TOTAL_W:0]   sum;
	logic [crp_pkg::TOTAL_W-1:0] sat_sum;
	logic [crp_pkg::NUM_W-1:0]   product;
	logic [DIV_W-1:0]            dividend_q;
	logic [crp_pkg::POP_W-1:0]   rem_q;
	logic [crp_pkg::RATE_W-1:0]  quot_q;
	logic                        ovf_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [crp_pkg::POP_W:0]     trial;
	logic [crp_pkg::POP_W:0]     diff;
	logic                        fits;
	logic [crp_pkg::RATE_W-1:0]  rate;

	// Population register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= crp_pkg::POP_RESET;
		end else if (pop_we) begin
			pop_q <= pop_wdata;
		end
	end

	// Saturating sum of total and new cases
	assign sum     = {1'b0, case_total_q} + {1'b0, cases};
	assign sat_sum = sum[crp_pkg::TOTAL_W] ? crp_pkg::TOTAL_MAX : sum[crp_pkg::TOTAL_W-1:0];

	// Running total; restart after the last day
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_total_q <= '0;
		end else if (cmd.take) begin
			case_total_q <= last_day ? '0 : sat_sum;
		end
	end

	// Total reported for this item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			total_q <= sat_sum;
		end
	end

	// Scale by people count
	assign product = crp_pkg::NUM_W'(total_q) * crp_pkg::NUM_W'(crp_pkg::PER_PEOPLE);

	// Restoring division step
	assign trial = {rem_q, dividend_q[DIV_W-1]};
	assign diff  = trial - {1'b0, pop_q};
	assign fits  = trial >= {1'b0, pop_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dividend_q <= DIV_W'(product) << FRACTION_BITS;
			rem_q      <= '0;
			quot_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.step) begin
			dividend_q <= dividend_q << 1;
			rem_q      <= fits ? diff[crp_pkg::POP_W-1:0] : trial[crp_pkg::POP_W-1:0];
			quot_q     <= {quot_q[crp_pkg::RATE_W-2:0], fits};
			ovf_q      <= ovf_q | quot_q[crp_pkg::RATE_W-1];
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sts.last_step = cnt_q == CNT_W'(DIV_W - 1);

	// Saturate on zero population or quotient overflow
	assign rate = (pop_q == '0 || ovf_q) ? crp_pkg::RATE_MAX : quot_q;

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_tdata <= {total_q, rate};
			out_tuser <= total_q == crp_pkg::TOTAL_MAX;
		end
	end

endmodule
